FILE: hdl/owbm_pkg.sv
// shared types, codes and reset constants for the one-wire bus master
`default_nettype none

package owbm_pkg;

   // register file geometry
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // register indexes
   localparam logic [2:0] REG_RESET_LOW      = 3'd0;
   localparam logic [2:0] REG_PRESENCE_SMP   = 3'd1;
   localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
   localparam logic [2:0] REG_WRITE_ONE_LOW  = 3'd3;
   localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd4;
   localparam logic [2:0] REG_WRITE_SLOT     = 3'd5;
   localparam logic [2:0] REG_READ_LOW       = 3'd6;
   localparam logic [2:0] REG_READ_SMP       = 3'd7;

   // register reset values
   localparam logic [9:0] RST_RESET_LOW      = 10'd480;
   localparam logic [7:0] RST_PRESENCE_SMP   = 8'd70;
   localparam logic [9:0] RST_RESET_TAIL     = 10'd410;
   localparam logic [6:0] RST_WRITE_ONE_LOW  = 7'd6;
   localparam logic [6:0] RST_WRITE_ZERO_LOW = 7'd60;
   localparam logic [7:0] RST_WRITE_SLOT     = 8'd70;
   localparam logic [5:0] RST_READ_LOW       = 6'd2;
   localparam logic [5:0] RST_READ_SMP       = 6'd10;

   // fixed tail of a read slot
   localparam int unsigned READ_TAIL_TICKS_DEF = 50;

   // width of the in-phase tick counter
   localparam int unsigned TICK_W = 10;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_RST_LOW  = 3'd1,
      PH_RST_WAIT = 3'd2,
      PH_RST_TAIL = 3'd3,
      PH_WR_SLOT  = 3'd4,
      PH_RD_LOW   = 3'd5,
      PH_RD_WAIT  = 3'd6,
      PH_RD_TAIL  = 3'd7
   } phase_type;

   // timing registers as seen by the sequencer
   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [7:0] presence_sample_ticks;
      logic [9:0] reset_tail_ticks;
      logic [6:0] write_one_low_ticks;
      logic [6:0] write_zero_low_ticks;
      logic [7:0] write_slot_ticks;
      logic [5:0] read_low_ticks;
      logic [5:0] read_sample_ticks;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
      logic       rejected;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/owbm_csr.sv
// apb-style timing register file for the one-wire bus master
`default_nettype none

module owbm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [owbm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [owbm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [owbm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output owbm_pkg::cfg_type                     cfg
);
   import owbm_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RESET_LOW:      cfg_in.reset_low_ticks       = csr_pwdata[9:0];
            REG_PRESENCE_SMP:   cfg_in.presence_sample_ticks = csr_pwdata[7:0];
            REG_RESET_TAIL:     cfg_in.reset_tail_ticks      = csr_pwdata[9:0];
            REG_WRITE_ONE_LOW:  cfg_in.write_one_low_ticks   = csr_pwdata[6:0];
            REG_WRITE_ZERO_LOW: cfg_in.write_zero_low_ticks  = csr_pwdata[6:0];
            REG_WRITE_SLOT:     cfg_in.write_slot_ticks      = csr_pwdata[7:0];
            REG_READ_LOW:       cfg_in.read_low_ticks        = csr_pwdata[5:0];
            REG_READ_SMP:       cfg_in.read_sample_ticks     = csr_pwdata[5:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= RST_RESET_LOW;
         cfg_ff.presence_sample_ticks <= RST_PRESENCE_SMP;
         cfg_ff.reset_tail_ticks      <= RST_RESET_TAIL;
         cfg_ff.write_one_low_ticks   <= RST_WRITE_ONE_LOW;
         cfg_ff.write_zero_low_ticks  <= RST_WRITE_ZERO_LOW;
         cfg_ff.write_slot_ticks      <= RST_WRITE_SLOT;
         cfg_ff.read_low_ticks        <= RST_READ_LOW;
         cfg_ff.read_sample_ticks     <= RST_READ_SMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero extended
   always_comb begin
      case (reg_idx)
         REG_RESET_LOW:      csr_prdata = CSR_DATA_W'(cfg_ff.reset_low_ticks);
         REG_PRESENCE_SMP:   csr_prdata = CSR_DATA_W'(cfg_ff.presence_sample_ticks);
         REG_RESET_TAIL:     csr_prdata = CSR_DATA_W'(cfg_ff.reset_tail_ticks);
         REG_WRITE_ONE_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.write_one_low_ticks);
         REG_WRITE_ZERO_LOW: csr_prdata = CSR_DATA_W'(cfg_ff.write_zero_low_ticks);
         REG_WRITE_SLOT:     csr_prdata = CSR_DATA_W'(cfg_ff.write_slot_ticks);
         REG_READ_LOW:       csr_prdata = CSR_DATA_W'(cfg_ff.read_low_ticks);
         REG_READ_SMP:       csr_prdata = CSR_DATA_W'(cfg_ff.read_sample_ticks);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/owbm_seq.sv
// bus timing sequencer: phase state, tick counter, bit shifter and step logic
`default_nettype none

module owbm_seq #(
   parameter int unsigned READ_TAIL_TICKS = owbm_pkg::READ_TAIL_TICKS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [1:0]        kind,
   input  wire logic [7:0]        data_byte,
   input  wire logic              line_level,
   input  owbm_pkg::cfg_type      cfg,
   output owbm_pkg::rsp_type      rsp
);
   import owbm_pkg::*;

   localparam logic [TICK_W-1:0] TAIL_LEN = TICK_W'(READ_TAIL_TICKS);

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [2:0]        bit_index_ff, bit_index_in;
   logic [7:0]        shift_byte_ff, shift_byte_in;
   logic              presence_seen_ff, presence_seen_in;
   logic              line_drive_ff, line_drive_in;

   logic [TICK_W-1:0] tick_inc;
   logic [TICK_W-1:0] low_len;
   logic              done, pres, rej;
   logic [7:0]        rdata;

   assign tick_inc = tick_count_ff + 1'b1;
   assign low_len  = shift_byte_ff[0] ? TICK_W'(cfg.write_one_low_ticks)
                                      : TICK_W'(cfg.write_zero_low_ticks);

   // next state for one transaction
   always_comb begin
      phase_in         = phase_ff;
      tick_count_in    = tick_count_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      presence_seen_in = presence_seen_ff;
      line_drive_in    = line_drive_ff;
      done             = 1'b0;
      pres             = 1'b0;
      rdata            = '0;
      rej              = 1'b0;

      if (kind != KIND_TICK) begin
         // command: start only from idle
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            tick_count_in = '0;
            bit_index_in  = '0;
            line_drive_in = 1'b1;
            case (kind)
               KIND_RESET: begin
                  phase_in         = PH_RST_LOW;
                  presence_seen_in = 1'b0;
                  shift_byte_in    = '0;
               end
               KIND_WRITE: begin
                  phase_in      = PH_WR_SLOT;
                  shift_byte_in = data_byte;
               end
               default: begin
                  phase_in      = PH_RD_LOW;
                  shift_byte_in = '0;
               end
            endcase
         end
      end else begin
         // tick: advance the running phase
         tick_count_in = tick_inc;
         case (phase_ff)
            PH_RST_LOW: begin
               if (tick_inc >= TICK_W'(cfg.reset_low_ticks)) begin
                  line_drive_in = 1'b0;
                  phase_in      = PH_RST_WAIT;
                  tick_count_in = '0;
               end
            end
            PH_RST_WAIT: begin
               if (tick_inc >= TICK_W'(cfg.presence_sample_ticks)) begin
                  presence_seen_in = ~line_level;
                  phase_in         = PH_RST_TAIL;
                  tick_count_in    = '0;
               end
            end
            PH_RST_TAIL: begin
               if (tick_inc >= TICK_W'(cfg.reset_tail_ticks)) begin
                  phase_in      = PH_IDLE;
                  tick_count_in = '0;
                  done          = 1'b1;
                  pres          = presence_seen_ff;
               end
            end
            PH_WR_SLOT: begin
               if (tick_inc >= TICK_W'(cfg.write_slot_ticks)) begin
                  shift_byte_in = {1'b0, shift_byte_ff[7:1]};
                  tick_count_in = '0;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in  = '0;
                     phase_in      = PH_IDLE;
                     line_drive_in = 1'b0;
                     done          = 1'b1;
                  end else begin
                     bit_index_in  = bit_index_ff + 1'b1;
                     line_drive_in = 1'b1;
                  end
               end else begin
                  line_drive_in = (tick_inc < low_len);
               end
            end
            PH_RD_LOW: begin
               if (tick_inc >= TICK_W'(cfg.read_low_ticks)) begin
                  line_drive_in = 1'b0;
                  phase_in      = PH_RD_WAIT;
                  tick_count_in = '0;
               end
            end
            PH_RD_WAIT: begin
               if (tick_inc >= TICK_W'(cfg.read_sample_ticks)) begin
                  shift_byte_in = shift_byte_ff | (8'(line_level) << bit_index_ff);
                  phase_in      = PH_RD_TAIL;
                  tick_count_in = '0;
               end
            end
            PH_RD_TAIL: begin
               if (tick_inc >= TAIL_LEN) begin
                  tick_count_in = '0;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = '0;
                     phase_in     = PH_IDLE;
                     done         = 1'b1;
                     rdata        = shift_byte_ff;
                  end else begin
                     bit_index_in  = bit_index_ff + 1'b1;
                     phase_in      = PH_RD_LOW;
                     line_drive_in = 1'b1;
                  end
               end
            end
            default: begin
               // idle tick leaves everything alone
               tick_count_in = tick_count_ff;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         tick_count_ff    <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         presence_seen_ff <= 1'b0;
         line_drive_ff    <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         tick_count_ff    <= tick_count_in;
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         presence_seen_ff <= presence_seen_in;
         line_drive_ff    <= line_drive_in;
      end
   end

   // result of this step
   assign rsp.drive_low = line_drive_in;
   assign rsp.busy_res  = (phase_in != PH_IDLE);
   assign rsp.done_res  = done;
   assign rsp.presence  = pres;
   assign rsp.read_data = rdata;
   assign rsp.rejected  = rej;

endmodule

`default_nettype wire

FILE: hdl/one_wire_bus_master.sv
// One-wire bus master timing sequencer, top level.
// Input channel req_*: each transaction is a tick (req_kind tick, with the
// sampled bus level on req_line_level) or a command (bus reset, write byte
// from req_data_byte, read byte). Commands arriving while an operation runs
// are ignored and come back with rsp_rejected set.
// Result channel rsp_*: exactly one result transaction per input transaction,
// in order, carrying the line drive, busy, done, presence and read byte.
// Timing registers are written over the csr_* apb-style port at byte address
// 4*index; pready is always high and a write lands on the access cycle.
// A transaction is held in the input register until the result register is
// free, then stepped into it. Throughput: one transaction per cycle while
// rsp_stall is low, set by the single sequencer step between the two registers.
// Reset (synchronous, active high) returns the sequencer to idle with the line
// released and loads the default timing values; no clearing pass follows.
// When rsp_stall is high the result register holds; the input register still
// takes one more transaction, after which req_stall rises until the result
// is taken.
`default_nettype none

module one_wire_bus_master #(
   parameter int unsigned READ_TAIL_TICKS = owbm_pkg::READ_TAIL_TICKS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_kind,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_line_level,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_drive_low,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_presence,
   output logic [7:0]                            rsp_read_data,
   output logic                                  rsp_rejected,
   // register port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [owbm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [owbm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [owbm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);
   import owbm_pkg::*;

   cfg_type    cfg;
   rsp_type    step_rsp;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_kind_ff;
   logic [7:0] in_data_ff;
   logic       in_level_ff;

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;

   logic       out_free;
   logic       advance;
   logic       req_take;

   // handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff  <= req_kind;
         in_data_ff  <= req_data_byte;
         in_level_ff <= req_line_level;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   owbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   owbm_seq #(
      .READ_TAIL_TICKS (READ_TAIL_TICKS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .kind       (in_kind_ff),
      .data_byte  (in_data_ff),
      .line_level (in_level_ff),
      .cfg        (cfg),
      .rsp        (step_rsp)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_drive_low = out_ff.drive_low;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_presence  = out_ff.presence;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_rejected  = out_ff.rejected;

endmodule

`default_nettype wire

FILE: hdl/owbm_chk.sv
// port-level checker for the one-wire bus master and its bind
`default_nettype none

module owbm_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_busy_res,
   input wire logic       rsp_done_res,
   input wire logic       rsp_presence,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_rejected
);

   // a completing transaction leaves the master idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // presence and read byte are only reported on completion
   a_report_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_presence || (rsp_read_data != 8'd0)) |-> rsp_done_res)
      else $error("presence or read byte outside a completion");

   // a rejected command means an operation is running and nothing completed
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && !rsp_done_res)
      else $error("rejected command while idle or on completion");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_done_res) && $stable(rsp_busy_res))
      else $error("stalled result changed");

endmodule

bind one_wire_bus_master owbm_chk u_owbm_chk (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_presence  (rsp_presence),
   .rsp_read_data (rsp_read_data),
   .rsp_rejected  (rsp_rejected)
);

`default_nettype wire
